// ===== rtl/pitch_yaw_frame_rotation_defines.svh =====
// Assertion macros shared by the pitch/yaw frame rotation RTL.
// Depends on nothing; users provide clk and arst_n in the including module.
`ifndef PITCH_YAW_FRAME_ROTATION_DEFINES_SVH
`define PITCH_YAW_FRAME_ROTATION_DEFINES_SVH
`ifndef SYNTHESIS
`define PYFR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PYFR_ASSERT_NEVER(name, cond, msg) \
	`PYFR_ASSERT(name, !(cond), msg)
`else
`define PYFR_ASSERT(name, prop, msg)
`define PYFR_ASSERT_NEVER(name, cond, msg)
`endif
`endif

// ===== rtl/pyfr_pkg.sv =====
// Shared constants and helper functions for the pitch/yaw frame rotation block.
// Used by the sine/cosine unit, the series terms and the top level.
package pyfr_pkg;

	localparam int DEF_COORD_WIDTH    = 32;
	localparam int DEF_ANGLE_WIDTH    = 16;
	localparam int DEF_TRIG_FRAC_BITS = 15;

	// Q30 fixed point constants used by the sine/cosine series.
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [29:0] HALF_Q30 = 30'h2000_0000;
	localparam logic [31:0] PI_Q30   = 32'hC90F_DAA2;

	localparam int SERIES_TERMS  = 6;
	localparam int TERM_STAGES   = 3;
	localparam int SINCOS_STAGES = 3 + TERM_STAGES * SERIES_TERMS + 1;
	localparam int ROTATE_STAGES = 3;

	// Divisor of the k-th sine term: 3!/1!, 5!/3!, ...
	function automatic int sin_divisor(input int k);
		return (2 * k + 2) * (2 * k + 3);
	endfunction

	// Divisor of the k-th cosine term: 2!/0!, 4!/2!, ...
	function automatic int cos_divisor(input int k);
		return (2 * k + 1) * (2 * k + 2);
	endfunction

endpackage

// ===== rtl/pyfr_delay.sv =====
// Enable-gated delay line of plain registers for data riding along the pipeline.
// Standalone; no package needed.
module pyfr_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

// ===== rtl/pyfr_series_term.sv =====
// One Taylor series term in three register stages: multiply by x^2, divide by
// a constant through a reciprocal, correct and accumulate. Uses pyfr_pkg.
module pyfr_series_term #(
	parameter int DIVISOR  = 6,
	parameter bit SUBTRACT = 1'b1
) (
	input  logic               clk,
	input  logic               en,
	input  logic [30:0]        t_in,
	input  logic [29:0]        x2_in,
	input  logic signed [32:0] sum_in,
	output logic [30:0]        t_out,
	output logic signed [32:0] sum_out
);
	import pyfr_pkg::*;

	// floor(2^31 / d) underestimates the quotient by at most one.
	localparam logic [30:0] RECIP = 31'((64'd1 << 31) / DIVISOR);
	localparam logic [60:0] BIAS  = 61'(HALF_Q30) + (61'(DIVISOR / 2) << 30);

	logic [60:0]        prod_s1;
	logic signed [32:0] sum_s1;

	logic [30:0]        dividend;
	logic [61:0]        qprod_s2;
	logic [30:0]        v_s2;
	logic signed [32:0] sum_s2;

	logic [30:0]        quot_est;
	logic [37:0]        back_prod;
	logic [37:0]        remainder;
	logic [30:0]        quot;

	logic [30:0]        t_s3;
	logic signed [32:0] sum_s3;

	assign dividend  = 31'((prod_s1 + BIAS) >> 30);
	assign quot_est  = qprod_s2[61:31];
	assign back_prod = 38'(quot_est) * 38'(DIVISOR);
	assign remainder = 38'(v_s2) - back_prod;
	assign quot      = quot_est + 31'(remainder >= 38'(DIVISOR));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= 61'(t_in) * 61'(x2_in);
			sum_s1   <= sum_in;
			qprod_s2 <= 62'(dividend) * 62'(RECIP);
			v_s2     <= dividend;
			sum_s2   <= sum_s1;
			t_s3     <= quot;
			if (SUBTRACT) begin
				sum_s3 <= sum_s2 - $signed({2'b00, quot});
			end else begin
				sum_s3 <= sum_s2 + $signed({2'b00, quot});
			end
		end
	end

	assign t_out   = t_s3;
	assign sum_out = sum_s3;

endmodule

// ===== rtl/pyfr_sincos.sv =====
// Pipelined sine and cosine of a binary angle: octant fold, radian scaling,
// x^2, a chain of series terms and quadrant sign fix. Uses pyfr_pkg.
module pyfr_sincos #(
	parameter int ANGLE_WIDTH    = pyfr_pkg::DEF_ANGLE_WIDTH,
	parameter int TRIG_FRAC_BITS = pyfr_pkg::DEF_TRIG_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [ANGLE_WIDTH-1:0]           angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);
	import pyfr_pkg::*;

	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

	localparam int F  = TRIG_FRAC_BITS;
	localparam int EW = F + 2;
	localparam logic [31:0] TRIG_RND = 32'(1) << (29 - F);

	logic [31:0] ang_full;
	logic [29:0] resid;
	logic        fold_swap;
	logic [29:0] fold_ang;

	logic [29:0] fold_s1;
	logic [61:0] xprod;
	logic [29:0] x_s2;
	logic [59:0] xsq;
	logic [29:0] x_s3;
	logic [29:0] x2_s3;

	logic [2:0]  side_d;
	quad_t       quad_d;
	logic        swap_d;

	logic [29:0]        x2_line  [SERIES_TERMS];
	logic [30:0]        sin_t    [SERIES_TERMS+1];
	logic signed [32:0] sin_sum  [SERIES_TERMS+1];
	logic [30:0]        cos_t    [SERIES_TERMS+1];
	logic signed [32:0] cos_sum  [SERIES_TERMS+1];

	logic [F:0]          sin_mag;
	logic [F:0]          cos_mag;
	logic signed [EW-1:0] s_fold;
	logic signed [EW-1:0] c_fold;
	logic signed [EW-1:0] sin_next;
	logic signed [EW-1:0] cos_next;
	logic signed [EW-1:0] sin_s4;
	logic signed [EW-1:0] cos_s4;

	function automatic logic [F:0] to_trig(input logic signed [32:0] v);
		logic [30:0] c;
		if (v < 0) begin
			c = '0;
		end else if (v > $signed({2'b00, ONE_Q30})) begin
			c = ONE_Q30;
		end else begin
			c = v[30:0];
		end
		return (F+1)'((32'(c) + TRIG_RND) >> (30 - F));
	endfunction

	// Fold the quadrant residue to at most an eighth of a turn.
	assign ang_full  = 32'(angle) << (32 - ANGLE_WIDTH);
	assign resid     = ang_full[29:0];
	assign fold_swap = resid > HALF_Q30;
	assign fold_ang  = fold_swap ? 30'(ONE_Q30 - 31'(resid)) : resid;

	assign xprod = 62'(fold_s1) * 62'(PI_Q30);
	assign xsq   = 60'(x_s2) * 60'(x_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			fold_s1 <= fold_ang;
			x_s2    <= 30'((63'(xprod) + 63'(ONE_Q30)) >> 31);
			x_s3    <= x_s2;
			x2_s3   <= 30'((61'(xsq) + 61'(HALF_Q30)) >> 30);
		end
	end

	pyfr_delay #(
		.WIDTH(3),
		.DEPTH(3 + TERM_STAGES * SERIES_TERMS)
	) u_side (
		.clk(clk),
		.en (en),
		.d  ({ang_full[31:30], fold_swap}),
		.q  (side_d)
	);

	assign quad_d = quad_t'(side_d[2:1]);
	assign swap_d = side_d[0];

	assign x2_line[0] = x2_s3;
	assign sin_t[0]   = {1'b0, x_s3};
	assign sin_sum[0] = $signed({3'b000, x_s3});
	assign cos_t[0]   = ONE_Q30;
	assign cos_sum[0] = $signed({2'b00, ONE_Q30});

	for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
		pyfr_series_term #(
			.DIVISOR (sin_divisor(k)),
			.SUBTRACT(1'((k % 2) == 0))
		) u_sin_term (
			.clk    (clk),
			.en     (en),
			.t_in   (sin_t[k]),
			.x2_in  (x2_line[k]),
			.sum_in (sin_sum[k]),
			.t_out  (sin_t[k+1]),
			.sum_out(sin_sum[k+1])
		);

		pyfr_series_term #(
			.DIVISOR (cos_divisor(k)),
			.SUBTRACT(1'((k % 2) == 0))
		) u_cos_term (
			.clk    (clk),
			.en     (en),
			.t_in   (cos_t[k]),
			.x2_in  (x2_line[k]),
			.sum_in (cos_sum[k]),
			.t_out  (cos_t[k+1]),
			.sum_out(cos_sum[k+1])
		);

		if (k < SERIES_TERMS - 1) begin : g_x2
			pyfr_delay #(
				.WIDTH(30),
				.DEPTH(TERM_STAGES)
			) u_x2_line (
				.clk(clk),
				.en (en),
				.d  (x2_line[k]),
				.q  (x2_line[k+1])
			);
		end
	end

	// The last term values are left over; only the sums matter at the end.
	assign sin_mag = to_trig(sin_sum[SERIES_TERMS]);
	assign cos_mag = to_trig(cos_sum[SERIES_TERMS]);
	assign s_fold  = swap_d ? $signed({1'b0, cos_mag}) : $signed({1'b0, sin_mag});
	assign c_fold  = swap_d ? $signed({1'b0, sin_mag}) : $signed({1'b0, cos_mag});

	always_comb begin
		case (quad_d)
			QUAD_0: begin
				sin_next = s_fold;
				cos_next = c_fold;
			end
			QUAD_1: begin
				sin_next = c_fold;
				cos_next = -s_fold;
			end
			QUAD_2: begin
				sin_next = -s_fold;
				cos_next = -c_fold;
			end
			QUAD_3: begin
				sin_next = -c_fold;
				cos_next = s_fold;
			end
			default: begin
				sin_next = s_fold;
				cos_next = c_fold;
			end
		endcase
	end

	// Stage 4 follows the series chain.
	always_ff @(posedge clk) begin
		if (en) begin
			sin_s4 <= sin_next;
			cos_s4 <= cos_next;
		end
	end

	assign sin_val = sin_s4;
	assign cos_val = cos_s4;

	// The series term outputs past the last one are not needed.
	logic unused_terms;
	assign unused_terms = ^{sin_t[SERIES_TERMS], cos_t[SERIES_TERMS]};

endmodule

// ===== rtl/pyfr_rotate.sv =====
// Rotation matrix build and matrix-vector product in three register stages,
// with rounding and saturation of each component. Uses pyfr_pkg.
module pyfr_rotate #(
	parameter int COORD_WIDTH    = pyfr_pkg::DEF_COORD_WIDTH,
	parameter int TRIG_FRAC_BITS = pyfr_pkg::DEF_TRIG_FRAC_BITS
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic                             kind,
	input  logic signed [COORD_WIDTH-1:0]    coord_x,
	input  logic signed [COORD_WIDTH-1:0]    coord_y,
	input  logic signed [COORD_WIDTH-1:0]    coord_z,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_p,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_p,
	input  logic signed [TRIG_FRAC_BITS+1:0] sin_y,
	input  logic signed [TRIG_FRAC_BITS+1:0] cos_y,
	output logic signed [COORD_WIDTH-1:0]    out_x,
	output logic signed [COORD_WIDTH-1:0]    out_y,
	output logic signed [COORD_WIDTH-1:0]    out_z,
	output logic                             saturated
);
	import pyfr_pkg::*;

	localparam logic KIND_FWD = 1'b0;
	localparam logic KIND_INV = 1'b1;

	localparam int CW = COORD_WIDTH;
	localparam int F  = TRIG_FRAC_BITS;
	localparam int EW = F + 2;
	localparam int PW = CW + EW;
	localparam int SW = PW + 2;
	localparam int RW = SW - F;

	localparam logic signed [2*EW-1:0] RND_P   = (2*EW)'(1) << (F - 1);
	localparam logic signed [SW-1:0]   RND_R   = SW'(1) << (F - 1);
	localparam logic signed [RW-1:0]   SAT_MAX = {{5{1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [RW-1:0]   SAT_MIN = {{5{1'b1}}, {(CW-1){1'b0}}};

	logic signed [EW-1:0] spsy;
	logic signed [EW-1:0] cpsy;
	logic signed [EW-1:0] spcy;
	logic signed [EW-1:0] cpcy;
	logic signed [EW-1:0] mat   [3][3];
	logic signed [EW-1:0] mat_s1   [3][3];
	logic signed [CW-1:0] coord_s1 [3];
	logic signed [PW-1:0] prod_s2  [3][3];

	logic signed [SW-1:0] total   [3];
	logic signed [RW-1:0] shifted [3];
	logic signed [CW-1:0] row_val [3];
	logic [2:0]           row_sat;

	logic signed [CW-1:0] res_s3 [3];
	logic                 sat_s3;

	// Product of two trig values rounded half up back to trig scale.
	function automatic logic signed [EW-1:0] trig_mul(
		input logic signed [EW-1:0] a,
		input logic signed [EW-1:0] b
	);
		logic signed [2*EW-1:0] p;
		logic signed [2*EW-1:0] r;
		p = a * b;
		r = (p + RND_P) >>> F;
		return EW'(r);
	endfunction

	assign spsy = trig_mul(sin_p, sin_y);
	assign cpsy = trig_mul(cos_p, sin_y);
	assign spcy = trig_mul(sin_p, cos_y);
	assign cpcy = trig_mul(cos_p, cos_y);

	always_comb begin
		case (kind)
			KIND_INV: begin
				mat[0][0] = cos_y; mat[0][1] = '0;     mat[0][2] = sin_y;
				mat[1][0] = -spsy; mat[1][1] = cos_p;  mat[1][2] = spcy;
				mat[2][0] = -cpsy; mat[2][1] = -sin_p; mat[2][2] = cpcy;
			end
			KIND_FWD: begin
				mat[0][0] = cos_y; mat[0][1] = -spsy;  mat[0][2] = -cpsy;
				mat[1][0] = '0;    mat[1][1] = cos_p;  mat[1][2] = -sin_p;
				mat[2][0] = sin_y; mat[2][1] = spcy;   mat[2][2] = cpcy;
			end
			default: begin
				mat[0][0] = cos_y; mat[0][1] = -spsy;  mat[0][2] = -cpsy;
				mat[1][0] = '0;    mat[1][1] = cos_p;  mat[1][2] = -sin_p;
				mat[2][0] = sin_y; mat[2][1] = spcy;   mat[2][2] = cpcy;
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			total[i] = SW'(prod_s2[i][0]) + SW'(prod_s2[i][1]) + SW'(prod_s2[i][2]) + RND_R;
			shifted[i] = RW'(total[i] >>> F);
			row_sat[i] = (shifted[i] > SAT_MAX) || (shifted[i] < SAT_MIN);
			if (shifted[i] > SAT_MAX) begin
				row_val[i] = CW'(SAT_MAX);
			end else if (shifted[i] < SAT_MIN) begin
				row_val[i] = CW'(SAT_MIN);
			end else begin
				row_val[i] = shifted[i][CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mat_s1      <= mat;
			coord_s1[0] <= coord_x;
			coord_s1[1] <= coord_y;
			coord_s1[2] <= coord_z;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= PW'(coord_s1[j]) * PW'(mat_s1[i][j]);
				end
			end
			res_s3 <= row_val;
			sat_s3 <= |row_sat;
		end
	end

	assign out_x     = res_s3[0];
	assign out_y     = res_s3[1];
	assign out_z     = res_s3[2];
	assign saturated = sat_s3;

endmodule

// ===== rtl/pitch_yaw_frame_rotation.sv =====
// Top level of the pitch/yaw frame rotation: two sine/cosine pipelines, the
// rotation stages, a valid chain and the output register with skid. Uses pyfr_pkg.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   point   | in        | pt_valid / pt_stall   | kind, coord_x/y/z, pitch_angle, yaw_angle
//   result  | out       | res_valid / res_stall | out_x/y/z, saturated
//
// One item is accepted per cycle while pt_stall is low. It passes through 22 stages of
// sine/cosine (fold, radian scale, x^2, six series terms of three stages each, sign fix),
// three rotation stages and the output register before its result shows on res_valid.
// Reset clears only the valid chain, the output register valid and the skid valid.
// When res_stall holds a full output register, the skid takes the one item in flight and
// pt_stall, a register, then freezes the whole pipeline until the skid empties.

`include "pitch_yaw_frame_rotation_defines.svh"

module pitch_yaw_frame_rotation #(
	parameter int COORD_WIDTH    = pyfr_pkg::DEF_COORD_WIDTH,
	parameter int ANGLE_WIDTH    = pyfr_pkg::DEF_ANGLE_WIDTH,
	parameter int TRIG_FRAC_BITS = pyfr_pkg::DEF_TRIG_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pt_valid,
	output logic                          pt_stall,
	input  logic                          kind,
	input  logic signed [COORD_WIDTH-1:0] coord_x,
	input  logic signed [COORD_WIDTH-1:0] coord_y,
	input  logic signed [COORD_WIDTH-1:0] coord_z,
	input  logic [ANGLE_WIDTH-1:0]        pitch_angle,
	input  logic [ANGLE_WIDTH-1:0]        yaw_angle,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          saturated
);
	import pyfr_pkg::*;

	localparam int CW          = COORD_WIDTH;
	localparam int EW          = TRIG_FRAC_BITS + 2;
	localparam int PIPE_STAGES = SINCOS_STAGES + ROTATE_STAGES;
	localparam int SIDE_W      = 1 + 3 * CW;

	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	// The whole pipeline moves together; it stops only while the skid holds an item.
	logic pipe_en;
	logic take;
	logic arrive;

	logic [PIPE_STAGES-1:0] vld_q;

	logic [SIDE_W-1:0]    side_d;
	logic                 kind_d;
	logic signed [CW-1:0] cx_d;
	logic signed [CW-1:0] cy_d;
	logic signed [CW-1:0] cz_d;

	logic signed [EW-1:0] sin_p;
	logic signed [EW-1:0] cos_p;
	logic signed [EW-1:0] sin_y;
	logic signed [EW-1:0] cos_y;

	logic signed [CW-1:0] rot_x;
	logic signed [CW-1:0] rot_y;
	logic signed [CW-1:0] rot_z;
	logic                 rot_sat;

	logic                 out_valid_q;
	logic signed [CW-1:0] out_x_q;
	logic signed [CW-1:0] out_y_q;
	logic signed [CW-1:0] out_z_q;
	logic                 out_sat_q;

	logic                 skid_valid_q;
	logic signed [CW-1:0] skid_x_q;
	logic signed [CW-1:0] skid_y_q;
	logic signed [CW-1:0] skid_z_q;
	logic                 skid_sat_q;

	assign pipe_en  = !skid_valid_q;
	assign pt_stall = skid_valid_q;

	// Valid bits travel alongside the data through every pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (pipe_en) begin
			vld_q <= {vld_q[PIPE_STAGES-2:0], pt_valid};
		end
	end

	pyfr_sincos #(
		.ANGLE_WIDTH   (ANGLE_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_pitch_trig (
		.clk    (clk),
		.en     (pipe_en),
		.angle  (pitch_angle),
		.sin_val(sin_p),
		.cos_val(cos_p)
	);

	pyfr_sincos #(
		.ANGLE_WIDTH   (ANGLE_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_yaw_trig (
		.clk    (clk),
		.en     (pipe_en),
		.angle  (yaw_angle),
		.sin_val(sin_y),
		.cos_val(cos_y)
	);

	// The point and its kind wait beside the trig pipelines.
	pyfr_delay #(
		.WIDTH(SIDE_W),
		.DEPTH(SINCOS_STAGES)
	) u_point_line (
		.clk(clk),
		.en (pipe_en),
		.d  ({kind, coord_x, coord_y, coord_z}),
		.q  (side_d)
	);

	assign kind_d = side_d[SIDE_W-1];
	assign cx_d   = side_d[3*CW-1:2*CW];
	assign cy_d   = side_d[2*CW-1:CW];
	assign cz_d   = side_d[CW-1:0];

	pyfr_rotate #(
		.COORD_WIDTH   (COORD_WIDTH),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_rotate (
		.clk      (clk),
		.en       (pipe_en),
		.kind     (kind_d),
		.coord_x  (cx_d),
		.coord_y  (cy_d),
		.coord_z  (cz_d),
		.sin_p    (sin_p),
		.cos_p    (cos_p),
		.sin_y    (sin_y),
		.cos_y    (cos_y),
		.out_x    (rot_x),
		.out_y    (rot_y),
		.out_z    (rot_z),
		.saturated(rot_sat)
	);

	// An item leaves the last stage whenever the pipeline moves and that stage is valid.
	// It goes to the output register if that is free or being taken, else to the skid.
	assign take   = out_valid_q && !res_stall;
	assign arrive = pipe_en && vld_q[PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= arrive;
			end
		end else if (arrive) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			if (skid_valid_q) begin
				out_x_q   <= skid_x_q;
				out_y_q   <= skid_y_q;
				out_z_q   <= skid_z_q;
				out_sat_q <= skid_sat_q;
			end else if (arrive) begin
				out_x_q   <= rot_x;
				out_y_q   <= rot_y;
				out_z_q   <= rot_z;
				out_sat_q <= rot_sat;
			end
		end else if (arrive) begin
			skid_x_q   <= rot_x;
			skid_y_q   <= rot_y;
			skid_z_q   <= rot_z;
			skid_sat_q <= rot_sat;
		end
	end

	assign res_valid = out_valid_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign saturated = out_sat_q;

	// The skid only ever holds an item behind a held output item.
	`PYFR_ASSERT_NEVER(a_skid_alone, skid_valid_q && !out_valid_q, "skid holds an item with output empty")

	// The skid fills only when the output was stalled on the previous edge.
	`PYFR_ASSERT(a_skid_fill, $rose(skid_valid_q) |-> $past(out_valid_q && res_stall), "skid filled without a stall")

	// With nothing behind it, a taken output item leaves the output empty.
	`PYFR_ASSERT(a_drain, (take && !skid_valid_q && !vld_q[PIPE_STAGES-1]) |=> !res_valid, "item appeared from nowhere")

	// A flagged result has at least one component at a range bound.
	`PYFR_ASSERT(a_sat_bound, (res_valid && saturated) |-> (out_x == C_MAX || out_x == C_MIN || out_y == C_MAX || out_y == C_MIN || out_z == C_MAX || out_z == C_MIN), "saturation flag without a clipped component")

endmodule

// ===== verif/tb_pitch_yaw_frame_rotation.sv =====
// Self-checking testbench for pitch_yaw_frame_rotation: drives 3D points with gimbal angles
// and checks every rotated point against a bit-exact fixed-point model kept in a class.
// Depends on pyfr_pkg and the pitch_yaw_frame_rotation RTL.

module tb_pitch_yaw_frame_rotation;
	timeunit 1ns;
	timeprecision 1ps;

	// The block is instantiated with its default widths, taken from the package.
	localparam int CW = pyfr_pkg::DEF_COORD_WIDTH;
	localparam int AW = pyfr_pkg::DEF_ANGLE_WIDTH;
	localparam int TF = pyfr_pkg::DEF_TRIG_FRAC_BITS;

	// Q30 constants of the sine/cosine series: one, and pi as a Q30 scale for the
	// conversion from an eighth-turn folded binary angle to radians.
	localparam longint unsigned ONE_Q30_L  = 64'd1 << 30;
	localparam longint unsigned PI_RAD_Q30 = 64'd3373259426;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [CW-1:0] COORD_ONE = 1 <<< 16;

	// Latency from the accepting edge to res_valid, plus margin for the final drain.
	localparam int LATENCY     = 25;
	localparam int DRAIN_EXTRA = LATENCY + 15;

	typedef enum bit {ROT_FORWARD = 1'b0, ROT_INVERSE = 1'b1} rotation_kind_e;
	typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quadrant_e;

	typedef struct {
		rotation_kind_e       kind;
		logic signed [CW-1:0] x, y, z;
		logic [AW-1:0]        pitch, yaw;
	} point_t;

	typedef struct {
		logic signed [CW-1:0] x, y, z;
		logic                 sat;
	} rotated_t;

	// Keeps the rotated points still owed by the block, in acceptance order, and
	// compares each returned point against the oldest one.
	class rotation_checker;
		rotated_t expected_points[$];
		int       failures;

		// Taylor sum of sine (first = x, n0 = 3) or cosine (first = 1, n0 = 2) in Q30.
		// Each term comes from the previous one by a rounded multiply with x^2 and a
		// rounded division by (n-1)*n; the sum is clamped to [0, 1].
		function longint unsigned taylor_sum(longint unsigned x2, longint unsigned first,
				int n0);
			longint          sum;
			longint unsigned t, d;
			int              n;
			sum = longint'(first);
			t = first;
			for (n = n0; n <= n0 + 10; n += 2) begin
				d = longint'((n - 1) * n);
				t = (t * x2 + (ONE_Q30_L >> 1)) >> 30;
				t = (t + d / 2) / d;
				if (((n - n0) / 2) % 2 == 0)
					sum -= longint'(t);
				else
					sum += longint'(t);
			end
			if (sum < 0)
				sum = 0;
			if (sum > longint'(ONE_Q30_L))
				sum = longint'(ONE_Q30_L);
			return longint'(sum);
		endfunction

		function longint to_trig(longint unsigned v);
			return longint'((v + (64'd1 << (29 - TF))) >> (30 - TF));
		endfunction

		function void sin_cos(input logic [AW-1:0] a, output longint sn, output longint cs);
			logic [31:0]     ang;
			longint unsigned r, f, x, x2;
			longint          s, c, s0, c0;
			bit              folded;
			ang = 32'(a) << (32 - AW);
			r = longint'(ang[29:0]);
			// Past an eighth turn the residue is mirrored and sine and cosine swap.
			folded = r > (64'd1 << 29);
			f = folded ? ONE_Q30_L - r : r;
			x = (f * PI_RAD_Q30 + ONE_Q30_L) >> 31;
			x2 = (x * x + (ONE_Q30_L >> 1)) >> 30;
			s = to_trig(taylor_sum(x2, x, 3));
			c = to_trig(taylor_sum(x2, ONE_Q30_L, 2));
			s0 = folded ? c : s;
			c0 = folded ? s : c;
			case (quadrant_e'(ang[31:30]))
				QUAD_0: begin
					sn = s0;
					cs = c0;
				end
				QUAD_1: begin
					sn = c0;
					cs = -s0;
				end
				QUAD_2: begin
					sn = -s0;
					cs = -c0;
				end
				default: begin
					sn = -c0;
					cs = s0;
				end
			endcase
		endfunction

		// Product of two trig values, rounded half up back to TF fraction bits.
		function longint trig_product(longint a, longint b);
			return (a * b + (longint'(1) <<< (TF - 1))) >>> TF;
		endfunction

		function rotated_t rotate_point(point_t p);
			longint               sp, cp, sy, cy, acc, tmp, maxv, minv;
			longint               m[3][3];
			longint               v[3];
			logic signed [CW-1:0] o[3];
			rotated_t             r;
			maxv = (longint'(1) <<< (CW - 1)) - 1;
			minv = -maxv - 1;
			v[0] = longint'(p.x);
			v[1] = longint'(p.y);
			v[2] = longint'(p.z);
			sin_cos(p.pitch, sp, cp);
			sin_cos(p.yaw, sy, cy);
			m[0] = '{cy, -trig_product(sp, sy), -trig_product(cp, sy)};
			m[1] = '{0, cp, -sp};
			m[2] = '{sy, trig_product(sp, cy), trig_product(cp, cy)};
			if (p.kind == ROT_INVERSE) begin
				for (int i = 0; i < 3; i++)
					for (int j = i + 1; j < 3; j++) begin
						tmp = m[i][j];
						m[i][j] = m[j][i];
						m[j][i] = tmp;
					end
			end
			r.sat = 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc = 0;
				for (int j = 0; j < 3; j++)
					acc += v[j] * m[i][j];
				acc = (acc + (longint'(1) <<< (TF - 1))) >>> TF;
				if (acc > maxv) begin
					acc = maxv;
					r.sat = 1'b1;
				end else if (acc < minv) begin
					acc = minv;
					r.sat = 1'b1;
				end
				o[i] = acc[CW-1:0];
			end
			r.x = o[0];
			r.y = o[1];
			r.z = o[2];
			return r;
		endfunction

		function void note_point(point_t p);
			expected_points.push_back(rotate_point(p));
		endfunction

		function void check_result(rotated_t got);
			rotated_t want;
			if (expected_points.size() == 0) begin
				$error("result item arrived with no point outstanding");
				failures++;
				return;
			end
			want = expected_points.pop_front();
			if (got.x !== want.x) begin
				$error("out_x mismatch: expected %0d, got %0d", want.x, got.x);
				failures++;
			end
			if (got.y !== want.y) begin
				$error("out_y mismatch: expected %0d, got %0d", want.y, got.y);
				failures++;
			end
			if (got.z !== want.z) begin
				$error("out_z mismatch: expected %0d, got %0d", want.z, got.z);
				failures++;
			end
			if (got.sat !== want.sat) begin
				$error("saturated mismatch: expected %0b, got %0b", want.sat, got.sat);
				failures++;
			end
		endfunction

		function int outstanding();
			return expected_points.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 pt_valid = 1'b0;
	logic                 pt_stall;
	logic                 kind = 1'b0;
	logic signed [CW-1:0] coord_x = '0;
	logic signed [CW-1:0] coord_y = '0;
	logic signed [CW-1:0] coord_z = '0;
	logic [AW-1:0]        pitch_angle = '0;
	logic [AW-1:0]        yaw_angle = '0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic                 saturated;

	// Set by the stimulus to ask the receiver for one long hold-off while points keep coming.
	bit hold_wanted = 1'b0;

	rotation_checker rotations = new;

	pitch_yaw_frame_rotation u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt_valid   (pt_valid),
		.pt_stall   (pt_stall),
		.kind       (kind),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.coord_z    (coord_z),
		.pitch_angle(pitch_angle),
		.yaw_angle  (yaw_angle),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.saturated  (saturated)
	);

	always #10 clk = ~clk;

	// Offers one point and holds it until the block takes it. The payload and valid are
	// set right after a rising edge; pt_stall is read as it stood at the following edge.
	task automatic send_point(point_t p);
		pt_valid <= 1'b1;
		kind <= p.kind;
		coord_x <= p.x;
		coord_y <= p.y;
		coord_z <= p.z;
		pitch_angle <= p.pitch;
		yaw_angle <= p.yaw;
		do
			@(posedge clk);
		while (pt_stall);
		rotations.note_point(p);
	endtask

	task automatic idle_input(int cycles);
		pt_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops offering points until every outstanding rotated point has come back.
	task automatic drain_results();
		pt_valid <= 1'b0;
		while (rotations.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic point_t make_point(rotation_kind_e k, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic signed [CW-1:0] z, logic [AW-1:0] pitch,
			logic [AW-1:0] yaw);
		point_t p;
		p.kind = k;
		p.x = x;
		p.y = y;
		p.z = z;
		p.pitch = pitch;
		p.yaw = yaw;
		return p;
	endfunction

	// Four in ten coordinates are full-range, which often clip; the rest small, shifted down or
	// taken from the extremes so that unclipped results are common too.
	function automatic logic signed [CW-1:0] random_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: return $urandom_range(0, 1 << 21) - (1 << 20);
			7: begin
				case ($urandom_range(0, 6))
					0: return COORD_MAX;
					1: return COORD_MIN;
					2: return '0;
					3: return -1;
					4: return 1;
					5: return COORD_ONE;
					default: return -COORD_ONE;
				endcase
			end
			default: return $signed(CW'($urandom)) >>> $urandom_range(1, 24);
		endcase
	endfunction

	// A quarter of the angles sit on or next to a multiple of an eighth turn, where the
	// quadrant select and the fold change over.
	function automatic logic [AW-1:0] random_angle();
		if ($urandom_range(0, 3) == 0)
			return AW'($urandom_range(0, 7) * (1 << (AW - 3)) + $urandom_range(0, 2) - 1);
		return AW'($urandom);
	endfunction

	function automatic point_t random_point();
		return make_point(rotation_kind_e'($urandom_range(0, 1)), random_coord(),
			random_coord(), random_coord(), random_angle(), random_angle());
	endfunction

	// Bursts of random length separated by random gaps; about a quarter of the bursts run
	// straight into the next one with valid held high.
	task automatic random_points(int count);
		int sent;
		int burst;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 30);
			repeat (burst) begin
				send_point(random_point());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_input($urandom_range(1, 12));
		end
	endtask

	// Directed points: the zero vector, an all-ones vector, coordinate extremes with and
	// without clipping in both directions, each quadrant boundary for both angles, the
	// full-scale angle, and angles on either side of the eighth-turn fold.
	task automatic directed_points();
		logic signed [CW-1:0] a, b, c;
		a = COORD_ONE;
		b = 2 * COORD_ONE;
		c = -3 * COORD_ONE;
		send_point(make_point(ROT_FORWARD, '0, '0, '0, 0, 0));
		send_point(make_point(ROT_FORWARD, a, a, a, 0, 0));
		send_point(make_point(ROT_FORWARD, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
		send_point(make_point(ROT_INVERSE, COORD_MIN, COORD_MIN, COORD_MIN, 0, 0));
		// Rows that add up to about 1.7 times full scale clip high and low.
		send_point(make_point(ROT_FORWARD, COORD_MAX, COORD_MAX, COORD_MAX, 8192, 57344));
		send_point(make_point(ROT_FORWARD, COORD_MIN, COORD_MIN, COORD_MIN, 8192, 57344));
		send_point(make_point(ROT_INVERSE, COORD_MAX, COORD_MIN, COORD_MAX, 57344, 8192));
		send_point(make_point(ROT_INVERSE, COORD_MAX, COORD_MAX, COORD_MAX, 8192, 57344));
		send_point(make_point(ROT_INVERSE, COORD_MIN, COORD_MIN, COORD_MIN, 57344, 8192));
		send_point(make_point(ROT_FORWARD, COORD_MAX, COORD_MAX, COORD_MAX, 24576, 40960));
		send_point(make_point(ROT_FORWARD, a, b, c, 16384, 0));
		send_point(make_point(ROT_FORWARD, a, b, c, 32768, 16384));
		send_point(make_point(ROT_INVERSE, a, b, c, 49152, 32768));
		send_point(make_point(ROT_INVERSE, a, b, c, 0, 49152));
		send_point(make_point(ROT_FORWARD, a, b, c, 65535, 65535));
		send_point(make_point(ROT_FORWARD, a, b, c, 8192, 8193));
		send_point(make_point(ROT_INVERSE, a, b, c, 8191, 24576));
		send_point(make_point(ROT_FORWARD, a, b, c, 40960, 24577));
		send_point(make_point(ROT_INVERSE, -1, 1, -1, 1, 65535));
		send_point(make_point(ROT_FORWARD, COORD_MAX, '0, COORD_MIN, 16383, 49153));
		send_point(make_point(ROT_FORWARD, 12345678, -87654321, 55555, 12000, 53000));
		send_point(make_point(ROT_INVERSE, 12345678, -87654321, 55555, 12000, 53000));
	endtask

	// Result monitor: an item leaves the block at an edge where res_valid is high and
	// res_stall is low, both as they stood before the edge.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			rotations.check_result('{out_x, out_y, out_z, saturated});
	end

	// Receiver: segments of random length, each with its own stall pattern. On request it
	// holds off for a long stretch so that the pipeline fills and pushes back on pt_stall.
	initial begin : receiver
		int mode;
		int len;
		int k;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				res_stall <= 1'b1;
				repeat (120) @(posedge clk);
			end
			mode = $urandom_range(0, 9);
			len = $urandom_range(8, 60);
			if (mode == 9)
				len = $urandom_range(30, 80);
			for (k = 0; k < len; k++) begin
				case (mode)
					0, 1, 2: res_stall <= 1'b0;
					3, 4: res_stall <= ($urandom_range(0, 3) == 0);
					5, 6: res_stall <= ($urandom_range(0, 3) != 0);
					7: res_stall <= k[0];
					8: res_stall <= (k % 3 == 0);
					default: res_stall <= 1'b1;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_points();
		drain_results();

		random_points(200);

		// Long receiver hold-off while points are offered back to back: the block fills,
		// the skid takes the item in flight, and the input stalls.
		hold_wanted = 1'b1;
		repeat (150) send_point(random_point());

		// Pause until the block is empty, then resume.
		drain_results();
		random_points(200);
		drain_results();

		repeat (DRAIN_EXTRA) @(posedge clk);
		if (rotations.failures == 0 && rotations.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Run limit: well beyond the slowest correct run of roughly 600 points with gaps,
	// stalls and the long hold-off.
	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pyfr_pkg.sv
rtl/pyfr_delay.sv
rtl/pyfr_series_term.sv
rtl/pyfr_sincos.sv
rtl/pyfr_rotate.sv
rtl/pitch_yaw_frame_rotation.sv
verif/tb_pitch_yaw_frame_rotation.sv
